// ===== rtl/sfc_pkg.sv =====
// Shared types and fixed-point constants for the Stribeck friction coefficient block.
package sfc_pkg;

	localparam int NRM_W    = 16;
	localparam int VEL_W    = 24;
	localparam int MU_W     = 16;
	localparam int VS_W     = 24;
	localparam int REL_W    = VEL_W + 1;
	localparam int PR_W     = NRM_W + REL_W;
	localparam int DOT_W    = PR_W + 2;
	localparam int DN_W     = DOT_W + NRM_W;
	localparam int RND_SH   = 28;
	localparam int PROJ_W   = DN_W - RND_SH;
	localparam int T_W      = PROJ_W + 1;
	localparam int MAG_W    = 29;
	localparam int SQR_W    = 2 * MAG_W;
	localparam int SQ_W     = 60;
	localparam int SPEED_W  = SQ_W / 2;
	localparam int SPD_SH   = 16;
	localparam int DVD_W    = SPEED_W + SPD_SH;
	localparam int RATIO_W  = 21;
	localparam int REM_W    = VS_W + RATIO_W;
	localparam int Y_SH     = 10;
	localparam int Y_W      = RATIO_W + Y_SH;
	localparam int E_W      = 32;
	localparam int FRAC     = 31;
	localparam int PROD_W   = E_W + Y_W;
	localparam int RECIP_SH = 36;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam int MQ_W     = E_W + RECIP_W;
	localparam int SUM_W    = E_W + 2;
	localparam int TERMS    = 12;
	localparam int SQUARES  = 5;
	localparam int EP_W     = 2 * E_W;
	localparam int DIFF_W   = MU_W + 1;
	localparam int FP_W     = DIFF_W + E_W + 1;
	localparam int MUR_W    = FP_W - FRAC;
	localparam int MUS_W    = MUR_W + 1;

	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam logic [1:0] REG_MU_STATIC  = 2'd0;
	localparam logic [1:0] REG_MU_COULOMB = 2'd1;
	localparam logic [1:0] REG_STRIBECK_V = 2'd2;

	typedef struct packed {
		logic signed [NRM_W-1:0] normal_x;
		logic signed [NRM_W-1:0] normal_y;
		logic signed [NRM_W-1:0] normal_z;
		logic signed [VEL_W-1:0] parent_vel_x;
		logic signed [VEL_W-1:0] parent_vel_y;
		logic signed [VEL_W-1:0] parent_vel_z;
		logic signed [VEL_W-1:0] child_vel_x;
		logic signed [VEL_W-1:0] child_vel_y;
		logic signed [VEL_W-1:0] child_vel_z;
	} contact_t;

	typedef struct packed {
		logic            tangent_enable;
		logic [MU_W-1:0] friction_coeff;
	} coeff_t;

endpackage

// ===== rtl/sfc_isqrt.sv =====
// Pipelined integer square root, one result bit resolved per stage.
module sfc_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [sfc_pkg::SQ_W-1:0]    radicand,
	output logic                        out_valid,
	output logic [sfc_pkg::SPEED_W-1:0] root
);

	localparam int N = sfc_pkg::SPEED_W;
	localparam int W = sfc_pkg::SQ_W;

	logic         vld_s [N];
	logic [W-1:0] rem_s [N];
	logic [W-1:0] res_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam int SH = 2 * (N - 1 - k);
		localparam logic [W-1:0] BIT = W'(1) << SH;
		logic         cv;
		logic [W-1:0] crem, cres, trial;

		if (k == 0) begin : g_first
			assign cv   = in_valid;
			assign crem = radicand;
			assign cres = '0;
		end else begin : g_next
			assign cv   = vld_s[k-1];
			assign crem = rem_s[k-1];
			assign cres = res_s[k-1];
		end

		assign trial = cres + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= cv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (crem >= trial) begin
					rem_s[k] <= crem - trial;
					res_s[k] <= (cres >> 1) + BIT;
				end else begin
					rem_s[k] <= crem;
					res_s[k] <= cres >> 1;
				end
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign root      = res_s[N-1][N-1:0];

endmodule

// ===== rtl/sfc_decay.sv =====
// Pipelined speed-to-ratio divider and exp(-ratio) evaluator in Q.31.
module sfc_decay (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [sfc_pkg::SPEED_W-1:0] speed,
	input  logic [sfc_pkg::VS_W-1:0]    vs,
	output logic                        out_valid,
	output logic [sfc_pkg::E_W-1:0]     e
);

	localparam int RW = sfc_pkg::REM_W;
	localparam int QW = sfc_pkg::RATIO_W;
	localparam int EW = sfc_pkg::E_W;
	localparam int YW = sfc_pkg::Y_W;
	localparam int SW = sfc_pkg::SUM_W;
	localparam int PW = sfc_pkg::PROD_W;
	localparam int MW = sfc_pkg::MQ_W;
	localparam int NT = sfc_pkg::TERMS;
	localparam int NS = sfc_pkg::SQUARES;
	localparam int PE = sfc_pkg::EP_W;
	localparam int FR = sfc_pkg::FRAC;

	localparam logic [EW-1:0] ONE   = EW'(1) << FR;
	localparam logic [PE-1:0] HALF  = PE'(1) << (FR - 1);

	logic [sfc_pkg::DVD_W-1:0] dvd;
	logic [RW-1:0]             lim;
	logic                      ovf;
	logic                      d0_v_s, d0_z_s;
	logic [RW-1:0]             d0_rem_s;

	assign dvd = {speed, sfc_pkg::SPD_SH'(0)};
	assign lim = {vs, QW'(0)};
	assign ovf = (vs == '0) || (dvd >= {1'b0, lim});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d0_v_s <= 1'b0;
		end else if (en) begin
			d0_v_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d0_z_s   <= ovf;
			d0_rem_s <= dvd[RW-1:0];
		end
	end

	logic          dv_v_s   [QW];
	logic          dv_z_s   [QW];
	logic [RW-1:0] dv_rem_s [QW];
	logic [QW-1:0] dv_q_s   [QW];

	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int B = QW - 1 - j;
		logic          cv, cz;
		logic [RW-1:0] crem, dsh;
		logic [QW-1:0] cq;

		if (j == 0) begin : g_first
			assign cv   = d0_v_s;
			assign cz   = d0_z_s;
			assign crem = d0_rem_s;
			assign cq   = '0;
		end else begin : g_next
			assign cv   = dv_v_s[j-1];
			assign cz   = dv_z_s[j-1];
			assign crem = dv_rem_s[j-1];
			assign cq   = dv_q_s[j-1];
		end

		assign dsh = RW'(vs) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j] <= 1'b0;
			end else if (en) begin
				dv_v_s[j] <= cv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_z_s[j] <= cz;
				if (crem >= dsh) begin
					dv_rem_s[j] <= crem - dsh;
					dv_q_s[j]   <= cq | (QW'(1) << B);
				end else begin
					dv_rem_s[j] <= crem;
					dv_q_s[j]   <= cq;
				end
			end
		end
	end

	logic                 ta_v_s [1:NT];
	logic                 ta_z_s [1:NT];
	logic [PW-1:0]        ta_p_s [1:NT];
	logic signed [SW-1:0] ta_s_s [1:NT];
	logic [YW-1:0]        ta_y_s [1:NT];
	logic                 tb_v_s [1:NT];
	logic                 tb_z_s [1:NT];
	logic [MW-1:0]        tb_m_s [1:NT];
	logic [EW-1:0]        tb_x_s [1:NT];
	logic signed [SW-1:0] tb_s_s [1:NT];
	logic [YW-1:0]        tb_y_s [1:NT];
	logic                 tc_v_s [1:NT];
	logic                 tc_z_s [1:NT];
	logic [EW-1:0]        tc_t_s [1:NT];
	logic signed [SW-1:0] tc_s_s [1:NT];
	logic [YW-1:0]        tc_y_s [1:NT];

	for (genvar k = 1; k <= NT; k++) begin : g_term
		localparam logic [sfc_pkg::RECIP_W-1:0] RECIP =
			sfc_pkg::RECIP_W'((64'd1 << sfc_pkg::RECIP_SH) / k);
		localparam logic [EW-1:0] KC  = EW'(k);
		localparam bit            NEG = (k % 2) == 1;
		logic                 cv, cz;
		logic [EW-1:0]        ct;
		logic signed [SW-1:0] cs;
		logic [YW-1:0]        cy;
		logic [EW-1:0]        q0, r, qf;

		if (k == 1) begin : g_first
			assign cv = dv_v_s[QW-1];
			assign cz = dv_z_s[QW-1];
			assign ct = ONE;
			assign cs = SW'(signed'({1'b0, ONE}));
			assign cy = {dv_q_s[QW-1], sfc_pkg::Y_SH'(0)};
		end else begin : g_next
			assign cv = tc_v_s[k-1];
			assign cz = tc_z_s[k-1];
			assign ct = tc_t_s[k-1];
			assign cs = tc_s_s[k-1];
			assign cy = tc_y_s[k-1];
		end

		assign q0 = tb_m_s[k][sfc_pkg::RECIP_SH+EW-1:sfc_pkg::RECIP_SH];
		assign r  = tb_x_s[k] - q0 * KC;
		assign qf = (r >= KC) ? q0 + EW'(1) : q0;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ta_v_s[k] <= 1'b0;
				tb_v_s[k] <= 1'b0;
				tc_v_s[k] <= 1'b0;
			end else if (en) begin
				ta_v_s[k] <= cv;
				tb_v_s[k] <= ta_v_s[k];
				tc_v_s[k] <= tb_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ta_z_s[k] <= cz;
				ta_p_s[k] <= ct * cy;
				ta_s_s[k] <= cs;
				ta_y_s[k] <= cy;
				tb_z_s[k] <= ta_z_s[k];
				tb_x_s[k] <= ta_p_s[k][PW-1:FR];
				tb_m_s[k] <= ta_p_s[k][PW-1:FR] * RECIP;
				tb_s_s[k] <= ta_s_s[k];
				tb_y_s[k] <= ta_y_s[k];
				tc_z_s[k] <= tb_z_s[k];
				tc_t_s[k] <= qf;
				tc_y_s[k] <= tb_y_s[k];
				if (NEG) begin
					tc_s_s[k] <= tb_s_s[k] - SW'(signed'({2'b0, qf}));
				end else begin
					tc_s_s[k] <= tb_s_s[k] + SW'(signed'({2'b0, qf}));
				end
			end
		end
	end

	logic          sq_v_s [NS];
	logic          sq_z_s [NS];
	logic [PE-1:0] sq_p_s [NS];
	logic [EW-1:0] clamp_e;
	logic          fe_v_q;
	logic [EW-1:0] fe_q;
	logic [PE-1:0] last_r;

	always_comb begin
		if (tc_s_s[NT] < 0) begin
			clamp_e = '0;
		end else if (tc_s_s[NT] > SW'(signed'({1'b0, ONE}))) begin
			clamp_e = ONE;
		end else begin
			clamp_e = tc_s_s[NT][EW-1:0];
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_square
		logic          cv, cz;
		logic [EW-1:0] ce;

		if (i == 0) begin : g_first
			assign cv = tc_v_s[NT];
			assign cz = tc_z_s[NT];
			assign ce = clamp_e;
		end else begin : g_next
			logic [PE-1:0] rs;
			assign rs = sq_p_s[i-1] + HALF;
			assign cv = sq_v_s[i-1];
			assign cz = sq_z_s[i-1];
			assign ce = rs[FR+EW-1:FR];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[i] <= 1'b0;
			end else if (en) begin
				sq_v_s[i] <= cv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_z_s[i] <= cz;
				sq_p_s[i] <= ce * ce;
			end
		end
	end

	assign last_r = sq_p_s[NS-1] + HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_v_q <= 1'b0;
		end else if (en) begin
			fe_v_q <= sq_v_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fe_q <= sq_z_s[NS-1] ? '0 : last_r[FR+EW-1:FR];
		end
	end

	assign out_valid = fe_v_q;
	assign e         = fe_q;

endmodule

// ===== rtl/stribeck_friction_coefficient.sv =====
// Top level of the Stribeck friction coefficient pipeline with its register port.
//
// One contact transaction enters on the contact channel (normal and the two
// body velocities) and yields exactly one coefficient transaction on the
// coeff channel, in order. The pipeline takes one contact per cycle while
// its skid register is empty; its stages include the bit-per-stage square
// root (30 stages), the bit-per-stage divider and the twelve three-stage
// series terms of the exponential. The three coefficient registers are
// written through the APB port and read back at the same addresses. The
// user must write them only while no contact is in flight (not enforced).
// Reset clears the registers to zero and empties the pipeline. When the
// receiver stalls, one finished result moves into a skid register and the
// pipeline keeps accepting for that cycle; after that the whole pipeline
// holds its contents until the receiver takes the waiting result.
module stribeck_friction_coefficient (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        contact_valid,
	output logic                        contact_ready,
	input  sfc_pkg::contact_t           contact,
	output logic                        coeff_valid,
	input  logic                        coeff_ready,
	output sfc_pkg::coeff_t             coeff,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sfc_pkg::ADDR_W-1:0]  paddr,
	input  logic [sfc_pkg::DATA_W-1:0]  pwdata,
	output logic [sfc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	localparam int NW = sfc_pkg::NRM_W;
	localparam int VW = sfc_pkg::VEL_W;
	localparam int RL = sfc_pkg::REL_W;
	localparam int MU = sfc_pkg::MU_W;

	logic [MU-1:0]           mu_s_q, mu_c_q;
	logic [sfc_pkg::VS_W-1:0] vs_q;
	logic                    wr;
	logic                    adv;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_s_q <= '0;
			mu_c_q <= '0;
			vs_q   <= '0;
		end else if (wr) begin
			case (paddr[3:2])
				sfc_pkg::REG_MU_STATIC:  mu_s_q <= pwdata[MU-1:0];
				sfc_pkg::REG_MU_COULOMB: mu_c_q <= pwdata[MU-1:0];
				sfc_pkg::REG_STRIBECK_V: vs_q   <= pwdata[sfc_pkg::VS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			sfc_pkg::REG_MU_STATIC:  prdata = sfc_pkg::DATA_W'(mu_s_q);
			sfc_pkg::REG_MU_COULOMB: prdata = sfc_pkg::DATA_W'(mu_c_q);
			sfc_pkg::REG_STRIBECK_V: prdata = sfc_pkg::DATA_W'(vs_q);
			default:                 prdata = '0;
		endcase
	end

	logic signed [NW-1:0] nrm [3];
	logic signed [VW-1:0] pv  [3];
	logic signed [VW-1:0] cv  [3];

	assign nrm[0] = contact.normal_x;
	assign nrm[1] = contact.normal_y;
	assign nrm[2] = contact.normal_z;
	assign pv[0]  = contact.parent_vel_x;
	assign pv[1]  = contact.parent_vel_y;
	assign pv[2]  = contact.parent_vel_z;
	assign cv[0]  = contact.child_vel_x;
	assign cv[1]  = contact.child_vel_y;
	assign cv[2]  = contact.child_vel_z;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [NW-1:0]            n_s1 [3], n_s2 [3], n_s3 [3];
	logic signed [RL-1:0]            rel_s1 [3], rel_s2 [3], rel_s3 [3], rel_s4 [3];
	logic signed [sfc_pkg::PR_W-1:0] pr_s2 [3];
	logic signed [sfc_pkg::DOT_W-1:0] dot_s3;
	logic signed [sfc_pkg::DN_W-1:0] dn_s4 [3];
	logic [sfc_pkg::MAG_W-1:0]       mag_s5 [3];
	logic [sfc_pkg::SQR_W-1:0]       sqr_s6 [3];
	logic [sfc_pkg::SQ_W-1:0]        sq_s7;
	logic signed [sfc_pkg::DN_W-1:0]   dn_r [3];
	logic signed [sfc_pkg::T_W-1:0]    t_c  [3];
	logic signed [sfc_pkg::T_W-1:0]    a_c  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dn_r[i] = dn_s4[i] + sfc_pkg::DN_W'(1 << (sfc_pkg::RND_SH - 1));
			t_c[i]  = sfc_pkg::T_W'(rel_s4[i]) -
				sfc_pkg::T_W'(signed'(dn_r[i][sfc_pkg::DN_W-1:sfc_pkg::RND_SH]));
			a_c[i]  = (t_c[i] < 0) ? -t_c[i] : t_c[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= contact_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				n_s1[i]   <= nrm[i];
				rel_s1[i] <= RL'(pv[i]) - RL'(cv[i]);
				n_s2[i]   <= n_s1[i];
				rel_s2[i] <= rel_s1[i];
				pr_s2[i]  <= sfc_pkg::PR_W'(n_s1[i]) * sfc_pkg::PR_W'(rel_s1[i]);
				n_s3[i]   <= n_s2[i];
				rel_s3[i] <= rel_s2[i];
				rel_s4[i] <= rel_s3[i];
				dn_s4[i]  <= sfc_pkg::DN_W'(dot_s3) * sfc_pkg::DN_W'(n_s3[i]);
				mag_s5[i] <= a_c[i][sfc_pkg::MAG_W-1:0];
				sqr_s6[i] <= mag_s5[i] * mag_s5[i];
			end
			dot_s3 <= sfc_pkg::DOT_W'(pr_s2[0]) + sfc_pkg::DOT_W'(pr_s2[1]) +
				sfc_pkg::DOT_W'(pr_s2[2]);
			sq_s7  <= sfc_pkg::SQ_W'(sqr_s6[0]) + sfc_pkg::SQ_W'(sqr_s6[1]) +
				sfc_pkg::SQ_W'(sqr_s6[2]);
		end
	end

	logic                         rt_v;
	logic [sfc_pkg::SPEED_W-1:0]  speed;
	logic                         ex_v;
	logic [sfc_pkg::E_W-1:0]      ex_e;

	sfc_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s7),
		.radicand  (sq_s7),
		.out_valid (rt_v),
		.root      (speed)
	);

	sfc_decay u_decay (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (rt_v),
		.speed     (speed),
		.vs        (vs_q),
		.out_valid (ex_v),
		.e         (ex_e)
	);

	logic                               v_f1, v_f2;
	logic signed [sfc_pkg::FP_W-1:0]    prod_f1;
	sfc_pkg::coeff_t                    res_f2;
	logic signed [sfc_pkg::DIFF_W-1:0]  diff;
	logic signed [sfc_pkg::FP_W-1:0]    prod_r;
	logic signed [sfc_pkg::MUS_W-1:0]   mu_sum;
	logic [MU-1:0]                      mu_clamp;
	logic                               ena;

	assign diff   = signed'({1'b0, mu_s_q}) - signed'({1'b0, mu_c_q});
	assign prod_r = prod_f1 + sfc_pkg::FP_W'(1 << (sfc_pkg::FRAC - 1));
	assign mu_sum = signed'(sfc_pkg::MUS_W'(mu_c_q)) +
		sfc_pkg::MUS_W'(signed'(prod_r[sfc_pkg::FP_W-1:sfc_pkg::FRAC]));
	assign ena    = (mu_s_q != '0) || (mu_c_q != '0);

	always_comb begin
		if (mu_sum < 0) begin
			mu_clamp = '0;
		end else if (mu_sum > signed'(sfc_pkg::MUS_W'({MU{1'b1}}))) begin
			mu_clamp = '1;
		end else begin
			mu_clamp = mu_sum[MU-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1 <= 1'b0;
			v_f2 <= 1'b0;
		end else if (adv) begin
			v_f1 <= ex_v;
			v_f2 <= v_f1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_f1 <= sfc_pkg::FP_W'(diff) * signed'(sfc_pkg::FP_W'(ex_e));
			res_f2.tangent_enable <= ena;
			res_f2.friction_coeff <= ena ? mu_clamp : '0;
		end
	end

	logic            skid_v_q;
	sfc_pkg::coeff_t skid_q;

	assign adv           = !skid_v_q;
	assign contact_ready = adv;
	assign coeff_valid   = v_f2 || skid_v_q;
	assign coeff         = skid_v_q ? skid_q : res_f2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			skid_v_q <= !coeff_ready;
		end else begin
			skid_v_q <= v_f2 && !coeff_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			skid_q <= res_f2;
		end
	end

endmodule

// ===== rtl/sfc_checker.sv =====
// Port-level assertions for the friction coefficient block and their bind.
module sfc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       contact_valid,
	input logic                       contact_ready,
	input sfc_pkg::contact_t          contact,
	input logic                       coeff_valid,
	input logic                       coeff_ready,
	input sfc_pkg::coeff_t            coeff,
	input logic                       pready
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		coeff_valid && !coeff_ready |=> coeff_valid && $stable(coeff))
		else $error("A stalled coeff transaction changed or vanished.");

	a_off: assert property (@(posedge clk) disable iff (!arst_n)
		coeff_valid && !coeff.tangent_enable |-> coeff.friction_coeff == '0)
		else $error("A disabled contact reported a nonzero coefficient.");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!contact_ready |-> coeff_valid && $past(coeff_valid && !coeff_ready))
		else $error("Contact input stalled without a blocked result.");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		contact_valid && !contact_ready |=> contact_valid && $stable(contact))
		else $error("A waiting contact transaction changed or vanished.");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("The register port was not ready.");

endmodule

bind stribeck_friction_coefficient sfc_checker u_sfc_checker (.*);

// ===== dv/sfc_checker.sv =====
// Checker that snoops the channels and register writes, predicts each coefficient and compares.
`timescale 1ns / 1ps
module sfc_scoreboard (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       contact_valid,
	input  logic                       contact_ready,
	input  sfc_pkg::contact_t          contact,
	input  logic                       coeff_valid,
	input  logic                       coeff_ready,
	input  sfc_pkg::coeff_t            coeff,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sfc_pkg::ADDR_W-1:0] paddr,
	input  logic [sfc_pkg::DATA_W-1:0] pwdata,
	input  logic                       pready,
	output int                         errors,
	output int                         pending
);

	logic [15:0]     mu_s;
	logic [15:0]     mu_c;
	logic [23:0]     v_s;
	sfc_pkg::coeff_t coeff_q[$];

	function automatic longint round_shift(longint v, int k);
		logic [63:0] u;
		u = 64'(v) + (64'd1 << 62) + (64'd1 << (k - 1));
		return longint'(u >> k) - longint'((64'd1 << 62) >> k);
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] neg_exp(logic [63:0] r);
		logic [63:0] y;
		logic [63:0] term;
		logic [63:0] e;
		longint      sum;
		if (r >= (64'd32 << 16)) return 0;
		y = r << 10;
		term = 64'd1 << 31;
		sum = longint'(64'd1 << 31);
		for (int k = 1; k <= 12; k++) begin
			term = ((term * y) >> 31) / 64'(k);
			if (k % 2 == 1) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		if (sum > longint'(64'd1 << 31)) sum = longint'(64'd1 << 31);
		e = 64'(sum);
		for (int i = 0; i < 5; i++) e = (e * e + (64'd1 << 30)) >> 31;
		return e;
	endfunction

	function automatic sfc_pkg::coeff_t predict_coeff(sfc_pkg::contact_t c, logic [15:0] ms,
			logic [15:0] mc, logic [23:0] vs);
		longint          n[3];
		longint          rel[3];
		longint          t;
		longint          dot;
		longint          mu;
		logic [63:0]     sq;
		logic [63:0]     a;
		logic [63:0]     spd;
		logic [63:0]     e;
		sfc_pkg::coeff_t r;
		r = '0;
		if (ms == 0 && mc == 0) return r;
		n[0] = longint'(c.normal_x);
		n[1] = longint'(c.normal_y);
		n[2] = longint'(c.normal_z);
		rel[0] = longint'(c.parent_vel_x) - longint'(c.child_vel_x);
		rel[1] = longint'(c.parent_vel_y) - longint'(c.child_vel_y);
		rel[2] = longint'(c.parent_vel_z) - longint'(c.child_vel_z);
		dot = n[0] * rel[0] + n[1] * rel[1] + n[2] * rel[2];
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			t = rel[i] - round_shift(dot * n[i], 28);
			a = (t < 0) ? 64'(-t) : 64'(t);
			sq = sq + a * a;
		end
		spd = int_sqrt(sq);
		if (vs == 0) e = 0;
		else e = neg_exp((spd << 16) / {40'd0, vs});
		mu = longint'({48'd0, mc}) +
			round_shift((longint'({48'd0, ms}) - longint'({48'd0, mc})) * longint'(e), 31);
		if (mu < 0) mu = 0;
		if (mu > 65535) mu = 65535;
		r.tangent_enable = 1'b1;
		r.friction_coeff = 16'(mu);
		return r;
	endfunction

	assign pending = coeff_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_s <= '0;
			mu_c <= '0;
			v_s <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				sfc_pkg::REG_MU_STATIC:  mu_s <= pwdata[15:0];
				sfc_pkg::REG_MU_COULOMB: mu_c <= pwdata[15:0];
				sfc_pkg::REG_STRIBECK_V: v_s <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	initial errors = 0;

	always @(posedge clk) begin
		sfc_pkg::coeff_t want;
		if (arst_n) begin
			if (contact_valid && contact_ready)
				coeff_q.push_back(predict_coeff(contact, mu_s, mu_c, v_s));
			if (coeff_valid && coeff_ready) begin
				if (coeff_q.size() == 0) begin
					$error("coeff transaction with no contact waiting");
					errors++;
				end else begin
					want = coeff_q.pop_front();
					if (coeff.tangent_enable !== want.tangent_enable) begin
						$error("tangent_enable: expected %0d, got %0d",
							want.tangent_enable, coeff.tangent_enable);
						errors++;
					end
					if (coeff.friction_coeff !== want.friction_coeff) begin
						$error("friction_coeff: expected %0d, got %0d",
							want.friction_coeff, coeff.friction_coeff);
						errors++;
					end
				end
			end
		end
	end
endmodule

// ===== dv/stribeck_friction_coefficient_test.sv =====
// Testbench top: stimulus for the Stribeck friction block, register phases and the verdict.
`timescale 1ns / 1ps
module stribeck_friction_coefficient_test;

	logic                       clk;
	logic                       arst_n;
	logic                       contact_valid;
	logic                       contact_ready;
	sfc_pkg::contact_t          contact;
	logic                       coeff_valid;
	logic                       coeff_ready;
	sfc_pkg::coeff_t            coeff;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [sfc_pkg::ADDR_W-1:0] paddr;
	logic [sfc_pkg::DATA_W-1:0] pwdata;
	logic [sfc_pkg::DATA_W-1:0] prdata;
	logic                       pready;
	int                         errors;
	int                         pending;
	logic                       contact_fire;
	logic                       quiet;
	int                         stuck;

	stribeck_friction_coefficient u_top (.*);

	sfc_scoreboard u_chk (
		.clk(clk), .arst_n(arst_n), .contact_valid(contact_valid),
		.contact_ready(contact_ready), .contact(contact), .coeff_valid(coeff_valid),
		.coeff_ready(coeff_ready), .coeff(coeff), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) contact_fire <= contact_valid && contact_ready;

	always @(posedge clk) begin
		if (!arst_n || (contact_valid && contact_ready) || (coeff_valid && coeff_ready) ||
				(psel && penable))
			stuck <= 0;
		else
			stuck <= stuck + 1;
		if (stuck >= 20000) begin
			$display("FAIL stribeck_friction_coefficient");
			$finish;
		end
	end

	initial begin
		int n;
		coeff_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (quiet) begin
				coeff_ready <= 1;
			end else if ($urandom_range(9) == 0) begin
				coeff_ready <= 0;
				n = $urandom_range(16, 1);
				repeat (n - 1) @(negedge clk);
			end else begin
				coeff_ready <= 1;
			end
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic settle();
		contact_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (110) @(negedge clk);
	endtask

	task automatic set_coeffs(logic [15:0] ms, logic [15:0] mc, logic [23:0] vs);
		settle();
		reg_write(sfc_pkg::REG_MU_STATIC, {16'd0, ms});
		reg_write(sfc_pkg::REG_MU_COULOMB, {16'd0, mc});
		reg_write(sfc_pkg::REG_STRIBECK_V, {8'd0, vs});
	endtask

	task automatic send_contact(sfc_pkg::contact_t c);
		int n;
		if (!quiet && $urandom_range(5) == 0) begin
			contact_valid <= 0;
			n = $urandom_range(16, 1);
			repeat (n) @(negedge clk);
		end
		contact_valid <= 1;
		contact <= c;
		do @(negedge clk); while (!contact_fire);
	endtask

	function automatic logic signed [15:0] rand_normal();
		int k;
		k = $urandom_range(3);
		if (k == 0) return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
		if (k == 1) return $urandom_range(1) ? 16'sd11585 : -16'sd11585;
		if (k == 2) return 16'($urandom_range(2000)) - 16'sd1000;
		return 16'($urandom_range(32768)) - 16'sd16384;
	endfunction

	function automatic logic signed [23:0] rand_vel();
		logic signed [23:0] v;
		v = 24'($urandom);
		return v >>> $urandom_range(23);
	endfunction

	function automatic sfc_pkg::contact_t rand_contact();
		sfc_pkg::contact_t c;
		c.normal_x = rand_normal();
		c.normal_y = rand_normal();
		c.normal_z = rand_normal();
		c.parent_vel_x = rand_vel();
		c.parent_vel_y = rand_vel();
		c.parent_vel_z = rand_vel();
		c.child_vel_x = rand_vel();
		c.child_vel_y = rand_vel();
		c.child_vel_z = rand_vel();
		return c;
	endfunction

	function automatic sfc_pkg::contact_t make_contact(int nx, int ny, int nz, int px, int py,
			int pz, int cx, int cy, int cz);
		sfc_pkg::contact_t c;
		c.normal_x = 16'(nx);
		c.normal_y = 16'(ny);
		c.normal_z = 16'(nz);
		c.parent_vel_x = 24'(px);
		c.parent_vel_y = 24'(py);
		c.parent_vel_z = 24'(pz);
		c.child_vel_x = 24'(cx);
		c.child_vel_y = 24'(cy);
		c.child_vel_z = 24'(cz);
		return c;
	endfunction

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) send_contact(rand_contact());
	endtask

	initial begin
		arst_n = 0;
		quiet = 0;
		contact_valid = 0;
		contact = '0;
		coeff_ready = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		stuck = 0;
		repeat (6) @(negedge clk);
		arst_n = 1;

		// Both coefficients still at reset: friction is disabled.
		send_contact(make_contact(16384, 0, 0, 65536, 0, 0, 0, 0, 0));
		random_phase(10);

		set_coeffs(16'd16384, 16'd8192, 24'd65536);
		send_contact(make_contact(0, 0, 16384, 1000, -2000, 3000, 1000, -2000, 3000));
		send_contact(make_contact(16384, 0, 0, 65536, 0, 0, 0, 0, 0));
		send_contact(make_contact(16384, 0, 0, 0, 65536, 0, 0, 0, 0));
		send_contact(make_contact(0, -16384, 0, 0, 0, 131072, 0, 0, 0));
		send_contact(make_contact(0, 0, 0, 8388607, 8388607, 8388607,
			-8388608, -8388608, -8388608));
		send_contact(make_contact(-16384, -16384, -16384, -8388608, -8388608, -8388608,
			8388607, 8388607, 8388607));
		send_contact(make_contact(16384, 16384, 16384, 8388607, -8388608, 8388607,
			-8388608, 8388607, -8388608));
		send_contact(make_contact(0, 0, 16384, 2097152, 0, 0, 0, 0, 0));
		send_contact(make_contact(0, 0, 16384, 2097151, 0, 0, 0, 0, 0));
		send_contact(make_contact(11585, 11585, 0, 30000, -5000, 7000, -1, 2, 3));
		send_contact(make_contact(300, -200, 100, 1, 1, 1, 0, 0, 0));
		random_phase(60);

		set_coeffs(16'd65535, 16'd0, 24'd1);
		send_contact(make_contact(0, 0, 16384, 0, 0, 0, 0, 0, 0));
		send_contact(make_contact(0, 0, 16384, 1, 0, 0, 0, 0, 0));
		random_phase(50);

		// Coulomb above static: the difference goes negative.
		set_coeffs(16'd0, 16'd65535, 24'd16777215);
		send_contact(make_contact(16384, 0, 0, 0, 8388607, 0, 0, -8388608, 0));
		random_phase(60);

		// Zero Stribeck velocity gives pure Coulomb friction.
		set_coeffs(16'd65535, 16'd65535, 24'd0);
		random_phase(40);

		set_coeffs(16'd12000, 16'd20000, 24'd4096);
		random_phase(60);

		set_coeffs(16'd20000, 16'd1, 24'd0);
		random_phase(30);

		for (int p = 0; p < 3; p++) begin
			set_coeffs(16'($urandom), 16'($urandom), 24'($urandom_range(200000)));
			random_phase(40);
		end

		set_coeffs(16'd30000, 16'd10000, 24'd300000);
		random_phase(40);
		// Hold off until the pipeline has drained, then resume.
		contact_valid <= 0;
		while (pending != 0) @(negedge clk);
		random_phase(40);

		quiet = 1;
		random_phase(60);
		contact_valid <= 0;

		while (pending != 0) @(negedge clk);
		repeat (150) @(negedge clk);
		if (errors == 0)
			$display("PASS stribeck_friction_coefficient");
		else
			$display("FAIL stribeck_friction_coefficient");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/sfc_pkg.sv
rtl/sfc_isqrt.sv
rtl/sfc_decay.sv
rtl/stribeck_friction_coefficient.sv
rtl/sfc_checker.sv
dv/sfc_checker.sv
dv/stribeck_friction_coefficient_test.sv
